// ===== rtl/bdsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdsc_pkg
// shared types, reset values and register codes of the debounce / socd block
// ----------------------------------------------------------------------------
package bdsc_pkg;

	// default sizing
	localparam int NUM_BUTTONS_DEF = 14;
	localparam int TIME_WIDTH_DEF  = 32;

	// pin mapping
	localparam int NUM_PIN_MAPS = 14;  // four d-pad plus ten face buttons
	localparam int NUM_DPAD     = 4;
	localparam int NUM_FACE     = 10;
	localparam int PIN_W        = 5;
	localparam int MAP_ALL_W    = NUM_PIN_MAPS * PIN_W;

	// widths of the stream words
	localparam int PIN_WORD_W = 32;
	localparam int NOW_W      = 32;
	localparam int IN_DATA_W  = PIN_WORD_W + NOW_W;
	localparam int OUT_DATA_W = 16;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 50;
	localparam int DEB_W       = 8;
	localparam int DPAD_MAP_W  = NUM_DPAD * PIN_W;
	localparam int FACE_MAP_W  = NUM_FACE * PIN_W;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_DPAD_MAP   = 2'd1,
		REG_BUTTON_MAP = 2'd2
	} cfg_reg_t;

	// register reset values
	localparam logic [DEB_W-1:0]      DEBOUNCE_RST   = 8'd25;
	localparam logic [DPAD_MAP_W-1:0] DPAD_MAP_RST   = 20'd100384;
	localparam logic [FACE_MAP_W-1:0] BUTTON_MAP_RST = '0;

	// settings seen by the debounce stage
	typedef struct packed {
		logic [DEB_W-1:0]      debounce_ms;
		logic [DPAD_MAP_W-1:0] dpad_pin_map;
		logic [FACE_MAP_W-1:0] button_pin_map;
	} cfg_t;

endpackage : bdsc_pkg
`default_nettype wire

// ===== rtl/bdsc_debounce.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdsc_debounce
// eager per-button debounce: held levels and last change times
// ----------------------------------------------------------------------------
module bdsc_debounce #(
	parameter int NUM_MAPPED = bdsc_pkg::NUM_PIN_MAPS,
	parameter int TIME_WIDTH = bdsc_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                upd,
	input  wire bdsc_pkg::cfg_t                      cfg,
	input  wire logic [bdsc_pkg::PIN_WORD_W-1:0]     pins,
	input  wire logic [TIME_WIDTH-1:0]               now,
	output logic      [NUM_MAPPED-1:0]               active_next
);

	logic [bdsc_pkg::MAP_ALL_W-1:0] map_all;
	logic [NUM_MAPPED-1:0]          active_q;
	logic [NUM_MAPPED-1:0]          take;
	logic [TIME_WIDTH-1:0]          last_q [NUM_MAPPED];

	assign map_all = {cfg.button_pin_map, cfg.dpad_pin_map};

	genvar g;
	for (g = 0; g < NUM_MAPPED; g++) begin : g_btn
		logic [bdsc_pkg::PIN_W-1:0] pin;
		logic                       level;
		logic [TIME_WIDTH-1:0]      due_time;

		assign pin      = map_all[g*bdsc_pkg::PIN_W +: bdsc_pkg::PIN_W];
		assign level    = pins[pin];
		// wraps at the time width, compared unsigned
		assign due_time = last_q[g] + TIME_WIDTH'(cfg.debounce_ms);
		assign take[g]  = (level != active_q[g]) && (due_time <= now);
		assign active_next[g] = take[g] ? level : active_q[g];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				last_q[g] <= '0;
			end else if (upd && take[g]) begin
				last_q[g] <= now;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (upd) begin
			active_q <= active_next;
		end
	end

`ifndef SYNTH
	a_hold_without_update: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(active_q))
		else $error("held levels moved without an update");

	a_change_stamps_time: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && take[0]) |=> (last_q[0] == $past(now)))
		else $error("accepted change did not store its time");

	a_change_flips_level: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && take[0]) |=> (active_q[0] != $past(active_q[0])))
		else $error("accepted change did not flip the held level");
`endif

endmodule : bdsc_debounce
`default_nettype wire

// ===== rtl/bdsc_socd.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdsc_socd
// opposing-direction cleaner with last-vertical and last-horizontal flags
// ----------------------------------------------------------------------------
module bdsc_socd (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          upd,
	input  wire logic [bdsc_pkg::NUM_DPAD-1:0] dpad_raw,
	output logic      [bdsc_pkg::NUM_DPAD-1:0] dpad_clean
);

	logic vert_last_up_q;
	logic horiz_last_left_q;
	logic vert_next;
	logic horiz_next;
	logic up, down, left, right;

	always_comb begin
		up         = dpad_raw[0];
		down       = dpad_raw[1];
		left       = dpad_raw[2];
		right      = dpad_raw[3];
		vert_next  = vert_last_up_q;
		horiz_next = horiz_last_left_q;

		if (dpad_raw[0] && dpad_raw[1]) begin
			if (vert_last_up_q) begin
				up = 1'b0;
			end else begin
				down = 1'b0;
			end
		end else begin
			vert_next = dpad_raw[0];
		end

		if (dpad_raw[2] && dpad_raw[3]) begin
			if (horiz_last_left_q) begin
				left = 1'b0;
			end else begin
				right = 1'b0;
			end
		end else begin
			horiz_next = dpad_raw[2];
		end

		dpad_clean = {right, left, down, up};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_last_up_q    <= 1'b0;
			horiz_last_left_q <= 1'b0;
		end else if (upd) begin
			vert_last_up_q    <= vert_next;
			horiz_last_left_q <= horiz_next;
		end
	end

endmodule : bdsc_socd
`default_nettype wire

// ===== rtl/button_debounce_socd_cleaner_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_socd_cleaner_unit
// eager button debounce over a sampled pin word, followed by socd cleaning
// of the d-pad; one result word per input word
// ----------------------------------------------------------------------------
// channel   dir  handshake                   payload
// s_*       in   s_tvalid / s_tready         pin_levels, now_ms
// m_*       out  m_tvalid / m_tready         dpad_out, buttons_out
// cfg_*     in   cfg_valid / cfg_ready       register index, write data
//
// one word per cycle sustained while m_tready stays high; each word passes the input
// register, then debounce + socd logic into the result register
// reset clears held levels, change times and socd flags, and loads the
// register defaults; no clearing pass, words are taken right after reset
// m_tready low holds the result word; the input register still takes one
// more word, then s_tready drops until the result moves on
// cfg_ready is always high; unknown register indexes are ignored
// ----------------------------------------------------------------------------
module button_debounce_socd_cleaner_unit #(
	parameter int NUM_BUTTONS = bdsc_pkg::NUM_BUTTONS_DEF,
	parameter int TIME_WIDTH  = bdsc_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// input stream
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [bdsc_pkg::IN_DATA_W-1:0]        s_tdata,   // pin_levels[31:0], now_ms[63:32]
	// result stream
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic      [bdsc_pkg::OUT_DATA_W-1:0]       m_tdata,   // dpad_out[3:0], buttons_out[13:4], zero[15:14]
	// register writes
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [bdsc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire logic [bdsc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// buttons beyond the pin maps never move, so they get no storage
	localparam int NUM_MAPPED = (NUM_BUTTONS < bdsc_pkg::NUM_PIN_MAPS) ?
	                            NUM_BUTTONS : bdsc_pkg::NUM_PIN_MAPS;

	// configuration registers
	bdsc_pkg::cfg_t cfg_q;

	// input register
	logic                              valid_s1;
	logic [bdsc_pkg::PIN_WORD_W-1:0]   pins_s1;
	logic [TIME_WIDTH-1:0]             now_s1;

	// result register
	logic                              out_valid_q;
	logic [bdsc_pkg::NUM_DPAD-1:0]     dpad_q;
	logic [bdsc_pkg::NUM_FACE-1:0]     buttons_q;

	logic                              out_ready;
	logic                              upd;
	logic [NUM_MAPPED-1:0]             active_next;
	logic [bdsc_pkg::NUM_PIN_MAPS-1:0] active_pad;
	logic [bdsc_pkg::NUM_DPAD-1:0]     dpad_clean;

	// ---------------------------------------------------------------- config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms    <= bdsc_pkg::DEBOUNCE_RST;
			cfg_q.dpad_pin_map   <= bdsc_pkg::DPAD_MAP_RST;
			cfg_q.button_pin_map <= bdsc_pkg::BUTTON_MAP_RST;
		end else if (cfg_valid) begin
			unique case (bdsc_pkg::cfg_reg_t'(cfg_index))
				bdsc_pkg::REG_DEBOUNCE: begin
					cfg_q.debounce_ms <= cfg_data[bdsc_pkg::DEB_W-1:0];
				end
				bdsc_pkg::REG_DPAD_MAP: begin
					cfg_q.dpad_pin_map <= cfg_data[bdsc_pkg::DPAD_MAP_W-1:0];
				end
				bdsc_pkg::REG_BUTTON_MAP: begin
					cfg_q.button_pin_map <= cfg_data[bdsc_pkg::FACE_MAP_W-1:0];
				end
				default: begin
					// unmapped index, nothing written
				end
			endcase
		end
	end

	// ---------------------------------------------------------- flow control
	// result register frees up when empty or when taken this cycle
	assign out_ready = !out_valid_q || m_tready;
	// the word in the input register is processed and state commits
	assign upd       = valid_s1 && out_ready;
	assign s_tready  = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pins_s1 <= s_tdata[bdsc_pkg::PIN_WORD_W-1:0];
			// time is kept at the configured width, wrapping there
			now_s1  <= TIME_WIDTH'(s_tdata[bdsc_pkg::IN_DATA_W-1:bdsc_pkg::PIN_WORD_W]);
		end
	end

	// ------------------------------------------------------------- datapath
	bdsc_debounce #(
		.NUM_MAPPED (NUM_MAPPED),
		.TIME_WIDTH (TIME_WIDTH)
	) u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (upd),
		.cfg         (cfg_q),
		.pins        (pins_s1),
		.now         (now_s1),
		.active_next (active_next)
	);

	// missing buttons read as released
	assign active_pad = bdsc_pkg::NUM_PIN_MAPS'(active_next);

	bdsc_socd u_socd (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd),
		.dpad_raw   (active_pad[bdsc_pkg::NUM_DPAD-1:0]),
		.dpad_clean (dpad_clean)
	);

	// -------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			dpad_q    <= dpad_clean;
			buttons_q <= active_pad[bdsc_pkg::NUM_PIN_MAPS-1:bdsc_pkg::NUM_DPAD];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, buttons_q, dpad_q};

`ifndef SYNTH
	a_processed_word_shows: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> m_tvalid)
		else $error("processed word missing from the result register");

	a_no_up_and_down: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("up and down both reported");

	a_no_left_and_right: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
		else $error("left and right both reported");
`endif

endmodule : button_debounce_socd_cleaner_unit
`default_nettype wire

// ===== dv/tb_button_debounce_socd_cleaner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_socd_cleaner_unit
// self-checking bench for the eager debounce and socd cleaning unit: sample
// words go in on the s_* stream with random gaps, result words are taken on
// the m_* stream with random stalls, and every result word is compared with a
// cycle-free model of the held levels, change times and socd flags
// ----------------------------------------------------------------------------
module tb_button_debounce_socd_cleaner_unit;

	// register index that the block has to ignore
	localparam logic [bdsc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	// ------------------------------------------------------------------------
	// expected result words, built from a model of the debounce and socd logic
	// ------------------------------------------------------------------------
	class debounce_scoreboard;
		bit [bdsc_pkg::DEB_W-1:0]        debounce_ms;
		bit [bdsc_pkg::DPAD_MAP_W-1:0]   dpad_map;
		bit [bdsc_pkg::FACE_MAP_W-1:0]   face_map;
		bit [bdsc_pkg::NUM_PIN_MAPS-1:0] held;
		bit [bdsc_pkg::NOW_W-1:0]        change_ms [bdsc_pkg::NUM_PIN_MAPS];
		bit                              last_up;
		bit                              last_left;
		bit [13:0]                       expected_q [$];  // {buttons, right, left, down, up}
		int n_results;
		int n_mismatch;
		int n_taken;
		int n_held_off;
		int n_vert_conflict;
		int n_horz_conflict;

		function new();
			debounce_ms = bdsc_pkg::DEBOUNCE_RST;
			dpad_map    = bdsc_pkg::DPAD_MAP_RST;
			face_map    = bdsc_pkg::BUTTON_MAP_RST;
			held        = '0;
			foreach (change_ms[i])
				change_ms[i] = '0;
			last_up     = 1'b0;
			last_left   = 1'b0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void write_reg(logic [bdsc_pkg::CFG_INDEX_W-1:0] idx,
			bit [bdsc_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				bdsc_pkg::REG_DEBOUNCE:   debounce_ms = data[bdsc_pkg::DEB_W-1:0];
				bdsc_pkg::REG_DPAD_MAP:   dpad_map    = data[bdsc_pkg::DPAD_MAP_W-1:0];
				bdsc_pkg::REG_BUTTON_MAP: face_map    = data[bdsc_pkg::FACE_MAP_W-1:0];
				default: ;
			endcase
		endfunction

		// one accepted sample word
		function void note_word(bit [bdsc_pkg::PIN_WORD_W-1:0] pins,
			bit [bdsc_pkg::NOW_W-1:0] now_ms);
			bit [bdsc_pkg::PIN_W-1:0] pin;
			bit [bdsc_pkg::NOW_W-1:0] due;
			bit up, dn, lf, rt;
			for (int i = 0; i < bdsc_pkg::NUM_PIN_MAPS; i++) begin
				if (i < bdsc_pkg::NUM_DPAD)
					pin = dpad_map[bdsc_pkg::PIN_W*i +: bdsc_pkg::PIN_W];
				else
					pin = face_map[bdsc_pkg::PIN_W*(i-bdsc_pkg::NUM_DPAD) +: bdsc_pkg::PIN_W];
				if (pins[pin] != held[i]) begin
					// sum wraps at the time width, so a change may pass early
					due = change_ms[i] + debounce_ms;
					if (due <= now_ms) begin
						held[i]      = pins[pin];
						change_ms[i] = now_ms;
						n_taken++;
					end else begin
						n_held_off++;
					end
				end
			end
			up = held[0];
			dn = held[1];
			lf = held[2];
			rt = held[3];
			if (up && dn) begin
				n_vert_conflict++;
				if (last_up)
					up = 1'b0;
				else
					dn = 1'b0;
			end else begin
				last_up = up;
			end
			if (lf && rt) begin
				n_horz_conflict++;
				if (last_left)
					lf = 1'b0;
				else
					rt = 1'b0;
			end else begin
				last_left = lf;
			end
			expected_q.push_back({held[bdsc_pkg::NUM_PIN_MAPS-1:bdsc_pkg::NUM_DPAD],
				rt, lf, dn, up});
		endfunction

		// one accepted result word
		function void check_word(logic [bdsc_pkg::OUT_DATA_W-1:0] rslt);
			bit [13:0] exp;
			if (expected_q.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("%0t: result word %h with nothing expected", $realtime, rslt);
				return;
			end
			exp = expected_q.pop_front();
			n_results++;
			if (rslt[3:0] !== exp[3:0] || rslt[13:4] !== exp[13:4] ||
				rslt[15:14] !== 2'b00) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("%0t: dpad exp %b got %b, buttons exp %b got %b, pad got %b",
						$realtime, exp[3:0], rslt[3:0], exp[13:4], rslt[13:4], rslt[15:14]);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset and block ports
	// ------------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                               s_tvalid  = 1'b0;
	logic                               s_tready;
	logic [bdsc_pkg::IN_DATA_W-1:0]     s_tdata   = '0;  // pin_levels[31:0], now_ms[63:32]
	logic                               m_tvalid;
	logic                               m_tready  = 1'b0;
	logic [bdsc_pkg::OUT_DATA_W-1:0]    m_tdata;  // dpad_out[3:0], buttons_out[13:4], zero[15:14]
	logic                               cfg_valid = 1'b0;
	logic                               cfg_ready;
	logic [bdsc_pkg::CFG_INDEX_W-1:0]   cfg_index = '0;
	logic [bdsc_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;

	// both sides drop their random gaps while this is set
	bit no_idle = 1'b0;
	int n_sent  = 0;
	int n_cfg   = 0;

	debounce_scoreboard sb;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	button_debounce_socd_cleaner_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// offer one sample word after a random gap; valid stays up between
	// back-to-back words so it is never dropped and raised in one step
	task automatic send_sample(bit [bdsc_pkg::PIN_WORD_W-1:0] pins,
		bit [bdsc_pkg::NOW_W-1:0] now_ms);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {now_ms, pins};
		do @(posedge clk); while (!s_tready);
		sb.note_word(pins, now_ms);
		n_sent++;
	endtask

	// stop sending and wait until every result word is back, with some margin
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write, only with the block idle
	task automatic write_cfg(logic [bdsc_pkg::CFG_INDEX_W-1:0] idx,
		logic [bdsc_pkg::CFG_DATA_W-1:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		n_cfg++;
		cfg_valid <= 1'b0;
	endtask

	// result side: random stall before each word, none while no_idle is set
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_word(m_tdata);
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		int r, bitpos;
		bit [bdsc_pkg::PIN_WORD_W-1:0] pad;
		bit [bdsc_pkg::NOW_W-1:0]      now;
		bit [bdsc_pkg::DEB_W-1:0]      deb;
		bit [63:0]                     wide;

		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: debounce 25, up/down/left/right on pins 0..3,
		// every face button on pin 0
		send_sample(32'hFFFF_FFFF, 32'd0);         // too early after reset
		send_sample(32'hFFFF_FFFF, 32'd24);        // one ms short
		send_sample(32'h0000_000F, 32'd25);        // exact boundary, both conflicts
		send_sample(32'h0000_0000, 32'd49);        // held off
		send_sample(32'h0000_0001, 32'd50);        // up alone sets the vertical flag
		send_sample(32'h0000_000B, 32'd75);        // down joins, right alone
		send_sample(32'h0000_000F, 32'd100);       // left joins right
		send_sample(32'h0000_0000, 32'd126);       // neither held clears flags
		send_sample(32'h0000_000F, 32'hFFFF_FFF0); // changes just before the wrap
		send_sample(32'h0000_0000, 32'd5);         // wrapped sum still ahead
		send_sample(32'h0000_0000, 32'd9);         // wrapped sum lets it through early
		send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF); // time steps back
		send_sample(32'h0000_000A, 32'h8000_1000); // down and right only
		send_sample(32'h0000_0005, 32'h8000_1100); // up and left only
		send_sample(32'h0000_000F, 32'h8000_1200); // up and left were last
		send_sample(32'h0000_0000, 32'h8000_1300);

		// zero debounce with every button on the top pin
		write_cfg(bdsc_pkg::REG_DEBOUNCE, '0);
		write_cfg(bdsc_pkg::REG_DPAD_MAP, {bdsc_pkg::CFG_DATA_W{1'b1}});
		write_cfg(bdsc_pkg::REG_BUTTON_MAP, {bdsc_pkg::CFG_DATA_W{1'b1}});
		send_sample(32'h8000_0000, 32'h8000_1300); // same time, still taken
		send_sample(32'h0000_0000, 32'h8000_1300);
		send_sample(32'h8000_0000, 32'h8000_1300);

		// longest debounce, every button on pin 0
		write_cfg(bdsc_pkg::REG_DEBOUNCE, {bdsc_pkg::CFG_DATA_W{1'b1}});
		write_cfg(bdsc_pkg::REG_DPAD_MAP, '0);
		write_cfg(bdsc_pkg::REG_BUTTON_MAP, '0);
		send_sample(32'h0000_0001, 32'h8000_13FE); // 254 ms later, pin 0 matches the held level
		send_sample(32'h0000_0001, 32'h8000_13FF); // 255 ms later, still no change
		send_sample(32'hFFFF_FFFE, 32'h8000_14FE);

		// random phases, each with its own settings
		pad = $urandom;
		now = 32'h8000_2000;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0:       deb = '0;
				1:       deb = '1;
				default: deb = $urandom_range(0, 60);
			endcase
			write_cfg(bdsc_pkg::REG_DEBOUNCE, deb);
			wide = {$urandom, $urandom};
			// all four directions on one pin puts both pairs in conflict while that pin is held
			write_cfg(bdsc_pkg::REG_DPAD_MAP,
				(phase == 2) ? '0 : wide[bdsc_pkg::DPAD_MAP_W-1:0]);
			wide = {$urandom, $urandom};
			write_cfg(bdsc_pkg::REG_BUTTON_MAP, wide[bdsc_pkg::FACE_MAP_W-1:0]);
			if (phase == 4) begin
				wide = {$urandom, $urandom};
				write_cfg(REG_UNUSED, wide[bdsc_pkg::CFG_DATA_W-1:0]);
			end
			if (phase == 3)
				now = 32'hFFFF_FE00;  // run across the time wrap
			no_idle = (phase == 3 || phase == 6);

			for (int k = 0; k < 80; k++) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					// button-like: a few pins move, time advances near the debounce
					repeat ($urandom_range(0, 2)) begin
						bitpos = $urandom_range(0, 31);
						pad[bitpos] = ~pad[bitpos];
					end
					now += $urandom_range(0, 2 * deb + 4);
				end else if (r < 85) begin
					// chatter on every pin
					pad = $urandom;
					now += $urandom_range(0, deb + 2);
				end else if (r < 92) begin
					// jump to any time at all
					bitpos = $urandom_range(0, 31);
					pad[bitpos] = ~pad[bitpos];
					now = $urandom;
				end else begin
					// time going backwards
					pad = $urandom;
					now -= $urandom_range(0, 50);
				end
				send_sample(pad, now);
				// hold off once until the pipe is empty
				if (phase == 4 && k == 40)
					drain();
			end
		end

		no_idle = 1'b0;
		drain();
		repeat (8) @(posedge clk);

		$display("run: %0d sample words sent, %0d result words checked, %0d register writes",
			n_sent, sb.n_results, n_cfg);
		$display("run: %0d changes taken, %0d held off, %0d up/down and %0d left/right conflicts",
			sb.n_taken, sb.n_held_off, sb.n_vert_conflict, sb.n_horz_conflict);
		if (sb.n_mismatch == 0 && sb.pending() == 0) begin
			$display("tb_button_debounce_socd_cleaner_unit OK");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.n_mismatch, sb.pending());
			$display("tb_button_debounce_socd_cleaner_unit NOT OK");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#10_000_000;
		$display("timeout with %0d results outstanding", sb.pending());
		$display("tb_button_debounce_socd_cleaner_unit NOT OK");
		$finish;
	end

endmodule

// ===== button_debounce_socd_cleaner_unit.f =====
rtl/bdsc_pkg.sv
rtl/bdsc_debounce.sv
rtl/bdsc_socd.sv
rtl/button_debounce_socd_cleaner_unit.sv
dv/tb_button_debounce_socd_cleaner_unit.sv
